// ===== hw/rtl/wfa_pkg.sv =====
// Shared types, constants and codes of the worst-fit allocator.
`default_nettype none
package wfa_pkg;

  localparam int HEAP_BYTES       = 1024;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int OFF_W            = 10;
  localparam int LEN_W            = 11;
  localparam int ST_W             = 2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] start;
  } seg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_INIT, CMD_START, CMD_RD_SCAN, CMD_CHK, CMD_END,
    CMD_RD_UP, CMD_UP_WR, CMD_SPLIT_A, CMD_SPLIT_B, CMD_EXACT,
    CMD_RD_NXT, CMD_NXT_NONE, CMD_NXT_LATCH, CMD_MERGE,
    CMD_RD_DRP, CMD_DRP_WR, CMD_DRP_END, CMD_OUT
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_END, S_INS, S_INS_WR, S_SPLIT_B,
    S_EXACT, S_NXT, S_NXT_CHK, S_MERGE, S_DRP, S_DRP_WR, S_OUT
  } state_t;

  typedef struct packed {
    logic zero;
    logic scan_end;
    logic hit;
    logic cur_used;
    logic is_free;
    logic found;
    logic full;
    logic ins_stop;
    logic nxt_ok;
    logic drp_stop;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wfa_datapath.sv =====
// Segment table memory, scan registers and result register of the allocator.
`default_nettype none
module wfa_datapath #(
  parameter int MAX_SEGMENTS = wfa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire wfa_pkg::cmd_t              cmd,
  input  wire logic                       in_kind,
  input  wire logic [wfa_pkg::LEN_W-1:0]  in_size,
  input  wire logic [wfa_pkg::OFF_W-1:0]  in_off,
  input  wire logic                       out_ready,
  output wfa_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  output logic [wfa_pkg::ST_W-1:0]        out_status,
  output logic [wfa_pkg::OFF_W-1:0]       out_off
);
  import wfa_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_data_r, prev_r, cur_r, next_r;
  seg_t wr_data;
  logic wr_en, rd_en;
  logic [CNT_W:0] wr_addr, rd_addr;

  logic [CNT_W-1:0] count_r, idx_r, best_idx_r;
  logic [1:0]       d_r;
  logic             kind_r, found_r, nfree_r, out_valid_r;
  logic [LEN_W-1:0] size_r, best_len_r;
  logic [OFF_W-1:0] off_r, best_start_r, aoff_r, out_off_r;
  logic [ST_W-1:0]  status_r, out_status_r;
  logic             pfree;

  assign pfree = (idx_r != '0) && !prev_r.used;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = {1'b0, idx_r};
    case (cmd)
      CMD_RD_UP:  rd_addr = {1'b0, idx_r} - 1'b1;
      CMD_RD_NXT: rd_addr = {1'b0, idx_r} + 1'b1;
      CMD_RD_DRP: rd_addr = {1'b0, idx_r} + (CNT_W+1)'(d_r);
      CMD_RD_SCAN: rd_addr = {1'b0, idx_r};
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {1'b0, idx_r};
    wr_data = rd_data_r;
    case (cmd)
      CMD_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{used: 1'b0, len: LEN_W'(HEAP_BYTES), start: '0};
      end
      CMD_UP_WR, CMD_DRP_WR: wr_en = 1'b1;
      CMD_SPLIT_A: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, best_idx_r} + 1'b1;
        wr_data = '{used: 1'b0, len: best_len_r - size_r,
                    start: best_start_r + size_r[OFF_W-1:0]};
      end
      CMD_SPLIT_B: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, best_idx_r};
        wr_data = '{used: 1'b1, len: size_r, start: best_start_r};
      end
      CMD_EXACT: begin
        wr_en   = 1'b1;
        wr_data = '{used: 1'b1, len: cur_r.len, start: cur_r.start};
      end
      CMD_MERGE: begin
        wr_en = 1'b1;
        if (pfree) begin
          wr_addr = {1'b0, idx_r} - 1'b1;
          wr_data = '{used: 1'b0,
                      len: prev_r.len + cur_r.len + (nfree_r ? next_r.len : '0),
                      start: prev_r.start};
        end else begin
          wr_data = '{used: 1'b0, len: cur_r.len + (nfree_r ? next_r.len : '0),
                      start: cur_r.start};
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_START: begin
          kind_r     <= in_kind;
          size_r     <= in_size;
          off_r      <= in_off;
          idx_r      <= '0;
          found_r    <= 1'b0;
          best_len_r <= '0;
          status_r   <= (in_kind == KIND_FREE) ? ST_IGNORED : ST_NOFIT;
          aoff_r     <= '0;
        end
        CMD_CHK: begin
          cur_r <= rd_data_r;
          if (!stat.hit) begin
            prev_r <= rd_data_r;
            idx_r  <= idx_r + 1'b1;
            if (kind_r == KIND_ALLOC && !rd_data_r.used &&
                rd_data_r.len > size_r && rd_data_r.len > best_len_r) begin
              best_len_r   <= rd_data_r.len;
              best_idx_r   <= idx_r;
              best_start_r <= rd_data_r.start;
              found_r      <= 1'b1;
            end
          end
        end
        CMD_END: begin
          if (found_r && stat.full) begin
            status_r <= ST_FULL;
          end
          idx_r <= count_r;
        end
        CMD_UP_WR: idx_r <= idx_r - 1'b1;
        CMD_SPLIT_B: begin
          count_r  <= count_r + 1'b1;
          status_r <= ST_DONE;
          aoff_r   <= best_start_r;
        end
        CMD_EXACT: begin
          status_r <= ST_DONE;
          aoff_r   <= cur_r.start;
        end
        CMD_NXT_NONE: nfree_r <= 1'b0;
        CMD_NXT_LATCH: begin
          nfree_r <= !rd_data_r.used;
          next_r  <= rd_data_r;
        end
        CMD_MERGE: begin
          status_r <= ST_DONE;
          d_r      <= 2'(pfree) + 2'(nfree_r);
          if (!pfree) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        CMD_DRP_WR: idx_r <= idx_r + 1'b1;
        CMD_DRP_END: count_r <= count_r - CNT_W'(d_r);
        CMD_OUT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= status_r;
          out_off_r    <= aoff_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.zero     = (size_r == '0);
    stat.scan_end = (idx_r >= count_r);
    stat.hit      = (kind_r == KIND_FREE) ? (rd_data_r.start == off_r) :
                    (!rd_data_r.used && rd_data_r.len == size_r);
    stat.cur_used = rd_data_r.used;
    stat.is_free  = kind_r;
    stat.found    = found_r;
    stat.full     = (count_r == CNT_W'(MAX_SEGMENTS));
    stat.ins_stop = ({1'b0, idx_r} <= ({1'b0, best_idx_r} + 1'b1));
    stat.nxt_ok   = (({1'b0, idx_r} + 1'b1) < {1'b0, count_r});
    stat.drp_stop = (d_r == 2'd0) ||
                    (({1'b0, idx_r} + (CNT_W+1)'(d_r)) >= {1'b0, count_r});
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_off    = out_off_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment count out of range");
  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SPLIT_B) |=> (count_r == $past(count_r) + 1'b1))
    else $error("split did not grow the table");
  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && cmd != CMD_INIT) |-> (wr_addr <= {1'b0, count_r}))
    else $error("table write beyond used entries");
  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SPLIT_A) |-> !stat.full)
    else $error("split with full table");

endmodule
`default_nettype wire

// ===== hw/rtl/wfa_ctrl.sv =====
// Sequencer of the allocator: scan, shift, merge and result steps.
`default_nettype none
module wfa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire wfa_pkg::dp_stat_t stat,
  output wfa_pkg::cmd_t          cmd,
  output logic                   in_ready
);
  import wfa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD: begin
        if (stat.zero && !stat.is_free) state_nxt = S_OUT;
        else if (stat.scan_end) state_nxt = S_END;
        else state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!stat.hit) state_nxt = S_RD;
        else if (!stat.is_free) state_nxt = S_EXACT;
        else if (stat.cur_used) state_nxt = S_NXT;
        else state_nxt = S_OUT;
      end
      S_END: begin
        if (!stat.is_free && stat.found && !stat.full) state_nxt = S_INS;
        else state_nxt = S_OUT;
      end
      S_INS: state_nxt = stat.ins_stop ? S_SPLIT_B : S_INS_WR;
      S_INS_WR: state_nxt = S_INS;
      S_SPLIT_B: state_nxt = S_OUT;
      S_EXACT: state_nxt = S_OUT;
      S_NXT: state_nxt = stat.nxt_ok ? S_NXT_CHK : S_MERGE;
      S_NXT_CHK: state_nxt = S_MERGE;
      S_MERGE: state_nxt = S_DRP;
      S_DRP: state_nxt = stat.drp_stop ? S_OUT : S_DRP_WR;
      S_DRP_WR: state_nxt = S_DRP;
      S_OUT: if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_INIT: cmd = CMD_INIT;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_START;
      end
      S_RD: if (!(stat.zero && !stat.is_free) && !stat.scan_end) cmd = CMD_RD_SCAN;
      S_CHK: cmd = CMD_CHK;
      S_END: cmd = CMD_END;
      S_INS: cmd = stat.ins_stop ? CMD_SPLIT_A : CMD_RD_UP;
      S_INS_WR: cmd = CMD_UP_WR;
      S_SPLIT_B: cmd = CMD_SPLIT_B;
      S_EXACT: cmd = CMD_EXACT;
      S_NXT: cmd = stat.nxt_ok ? CMD_RD_NXT : CMD_NXT_NONE;
      S_NXT_CHK: cmd = CMD_NXT_LATCH;
      S_MERGE: cmd = CMD_MERGE;
      S_DRP: cmd = stat.drp_stop ? CMD_DRP_END : CMD_RD_DRP;
      S_DRP_WR: cmd = CMD_DRP_WR;
      S_OUT: if (!stat.out_busy) cmd = CMD_OUT;
      default: cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/worst_fit_allocator_core.sv =====
// Worst-fit heap allocator with coalescing (an exactly fitting free segment is taken first): top level.
// Usage: send one request beat on the in_ channel; in_tuser selects allocate (0) or
// free (1), in_tdata carries the size and the offset. Each request returns exactly
// one beat on the out_ channel with a status code and the allocated offset.
// A request is worked through one table entry at a time over the segment table:
// the scan reads each segment visited (S_RD) and then checks it (S_CHK), an
// allocate split reads (S_INS) and writes back (S_INS_WR) each entry moved up, and
// a free merge reads (S_DRP) and writes back (S_DRP_WR) each entry moved down.
// One request is in work at a time.
// in_tready is high only between requests; the result sits in an output register
// and the next request is taken while it waits.
// Reset: one cycle after rst_n is released the table is set to one free segment
// covering the heap; in_tready rises after that cycle.
// When the receiver stalls, the finished result holds in the output register and
// the block waits before delivering the following one.
`default_nettype none
module worst_fit_allocator_core #(
  parameter int MAX_SEGMENTS = wfa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // req_size[10:0], free_offset[20:11], zero pad
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // status[1:0], alloc_offset[11:2], zero pad
);
  import wfa_pkg::*;

  cmd_t             cmd;
  dp_stat_t         stat;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] aoff;

  wfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  wfa_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser),
    .in_size    (in_tdata[LEN_W-1:0]),
    .in_off     (in_tdata[LEN_W+OFF_W-1:LEN_W]),
    .out_ready  (out_tready),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_status (status),
    .out_off    (aoff)
  );

  assign out_tdata = {4'b0, aoff, status};

endmodule
`default_nettype wire
